// ===== design/sc2a_pkg.sv =====
// Shared constants, scan-code tables and result type for the scan-code to ASCII decoder.
package sc2a_pkg;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned MAX_RES     = 3;

  localparam logic [7:0] CMD_LED       = 8'hED;
  localparam logic [7:0] SC_LSHIFT_ON  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_ON  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_OFF = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_OFF = 8'hB6;
  localparam logic [7:0] SC_CAPS       = 8'h3A;
  localparam logic [7:0] SC_SCROLL     = 8'h45;
  localparam logic [7:0] SC_ACK        = 8'hFA;
  localparam logic [7:0] SC_RESEND     = 8'hFE;
  localparam logic [7:0] NO_BYTE       = 8'hFF;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } res_t;

  localparam logic [7:0] PLAIN_MAP [128] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h5e, 8'h08, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h40, 8'h5b, 8'h0a, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
    8'h3a, 8'h00, 8'h00, 8'h5d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5c, 8'h00, 8'h00
  };

  localparam logic [7:0] SHIFTED_MAP [128] = '{
    8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h7e, 8'h3d, 8'h7e, 8'h08, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h60, 8'h7b, 8'h0a, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h2b,
    8'h2a, 8'h00, 8'h00, 8'h7d, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5f, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7c, 8'h00, 8'h00
  };

endpackage

// ===== design/sc2a_out_buf.sv =====
// Result buffer that holds up to three results of one scan code and drains them in order.
module sc2a_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [1:0]           load_n_i,
  input  sc2a_pkg::res_t       load_res_i [sc2a_pkg::MAX_RES],
  output logic                 free_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // value[7:0]
  output logic                 m_axis_tlast,
  output logic                 m_axis_tuser   // kind
);

  sc2a_pkg::res_t slot_q [sc2a_pkg::MAX_RES];
  logic [1:0]     cnt_q;
  logic           pop;

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign free_o        = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready);
  assign m_axis_tdata  = slot_q[0].value;
  assign m_axis_tlast  = slot_q[0].last;
  assign m_axis_tuser  = slot_q[0].kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= load_n_i;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= load_res_i;
    end else if (pop) begin
      for (int i = 0; i < sc2a_pkg::MAX_RES - 1; i++) begin
        slot_q[i] <= slot_q[i + 1];
      end
    end
  end

endmodule

// ===== design/scancode_to_ascii_with_led_commands.sv =====
// Top level of the set 1 scan-code to ASCII decoder with the keyboard LED command queue.
//
//   Channel  Dir  Signals                         Contents
//   s_axis   in   tvalid tready tdata[7:0]         scan_code
//   m_axis   out  tvalid tready tdata tlast tuser  value, last, kind
//   cfg      in   cfg_we_i cfg_wdata_i[2:0]        initial_leds
//
// A scan code is registered on acceptance and decoded into the result buffer once the buffer
// is free; the buffer then presents its results on the output port in order. Each code
// yields zero to two results and the buffer drains one per cycle, so the output port sets
// the pace. The input register refills while the last result of the previous code is taken.
// Reset needs no clearing pass; command queue entries are read only after being written.
module scancode_to_ascii_with_led_commands #(
  parameter int unsigned QUEUE_DEPTH = sc2a_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // scan_code[7:0]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // value[7:0]
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // kind
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NPUSH = 4;

  logic [2:0]       init_q;
  logic             in_valid_q;
  logic [7:0]       code_q;
  logic [1:0]       shift_q, shift_d;
  logic [2:0]       led_q, led_d;
  logic             start_q;
  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       bif_q, bif_d;
  logic             await_q, await_d;
  logic [7:0]       queue_mem [QUEUE_DEPTH];

  logic             push_en  [NPUSH];
  logic [PTR_W-1:0] push_idx [NPUSH];
  logic [7:0]       push_val [NPUSH];

  sc2a_pkg::res_t   res [sc2a_pkg::MAX_RES];
  logic [1:0]       res_n;
  logic             buf_free;
  logic             adv;

  function automatic logic [PTR_W-1:0] slot_of(logic [PTR_W-1:0] h, logic [CNT_W-1:0] c);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - PTR_W){1'b0}}, h} + {1'b0, c};
    if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] h);
    return (h == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : h + PTR_W'(1);
  endfunction

  assign adv           = in_valid_q && buf_free;
  assign s_axis_tready = !in_valid_q || buf_free;

  always_comb begin
    logic [7:0] ch;
    logic [7:0] hv;
    logic       pend;
    shift_d = shift_q;
    led_d   = led_q;
    head_d  = head_q;
    cnt_d   = cnt_q;
    bif_d   = bif_q;
    await_d = await_q;
    res_n   = 2'd0;
    ch      = 8'h00;
    hv      = 8'h00;
    pend    = 1'b0;
    for (int i = 0; i < sc2a_pkg::MAX_RES; i++) begin
      res[i] = '{kind: sc2a_pkg::KIND_CHAR, value: 8'h00, last: 1'b0};
    end
    for (int p = 0; p < NPUSH; p++) begin
      push_en[p]  = 1'b0;
      push_idx[p] = '0;
      push_val[p] = 8'h00;
    end

    // Boot command: the queue is empty and nothing is in flight here.
    if (start_q) begin
      led_d       = init_q;
      push_en[0]  = 1'b1;
      push_idx[0] = slot_of(head_d, cnt_d);
      push_val[0] = sc2a_pkg::CMD_LED;
      cnt_d       = cnt_d + CNT_W'(1);
      push_en[1]  = 1'b1;
      push_idx[1] = slot_of(head_d, cnt_d);
      push_val[1] = {5'b0, init_q};
      cnt_d       = cnt_d + CNT_W'(1);
      head_d      = next_ptr(head_d);
      cnt_d       = cnt_d - CNT_W'(1);
      bif_d       = sc2a_pkg::CMD_LED;
      await_d     = 1'b1;
      res[res_n]  = '{kind: sc2a_pkg::KIND_CMD, value: sc2a_pkg::CMD_LED, last: 1'b0};
      res_n       = res_n + 2'd1;
    end

    if (!code_q[7]) begin
      ch = (shift_d == 2'b00) ? sc2a_pkg::PLAIN_MAP[code_q[6:0]]
                              : sc2a_pkg::SHIFTED_MAP[code_q[6:0]];
    end
    if ((ch inside {[8'h41:8'h5A]}) && (led_d[2] == (shift_d != 2'b00))) begin
      ch = ch + sc2a_pkg::CASE_OFFSET;
    end
    if (ch != 8'h00) begin
      res[res_n] = '{kind: sc2a_pkg::KIND_CHAR, value: ch, last: 1'b0};
      res_n      = res_n + 2'd1;
    end

    if (code_q == sc2a_pkg::SC_LSHIFT_ON)  shift_d = shift_d | 2'b01;
    if (code_q == sc2a_pkg::SC_RSHIFT_ON)  shift_d = shift_d | 2'b10;
    if (code_q == sc2a_pkg::SC_LSHIFT_OFF) shift_d = shift_d & 2'b10;
    if (code_q == sc2a_pkg::SC_RSHIFT_OFF) shift_d = shift_d & 2'b01;
    if ((code_q == sc2a_pkg::SC_CAPS) || (code_q == sc2a_pkg::SC_SCROLL)) begin
      led_d = led_d ^ ((code_q == sc2a_pkg::SC_CAPS) ? 3'b100 : 3'b001);
      if (cnt_d < CNT_W'(QUEUE_DEPTH)) begin
        push_en[2]  = 1'b1;
        push_idx[2] = slot_of(head_d, cnt_d);
        push_val[2] = sc2a_pkg::CMD_LED;
        cnt_d       = cnt_d + CNT_W'(1);
      end
      if (cnt_d < CNT_W'(QUEUE_DEPTH)) begin
        push_en[3]  = 1'b1;
        push_idx[3] = slot_of(head_d, cnt_d);
        push_val[3] = {5'b0, led_d};
        cnt_d       = cnt_d + CNT_W'(1);
      end
    end
    if (code_q == sc2a_pkg::SC_ACK) begin
      await_d = 1'b0;
      bif_d   = sc2a_pkg::NO_BYTE;
    end
    if (code_q == sc2a_pkg::SC_RESEND) begin
      res[res_n] = '{kind: sc2a_pkg::KIND_CMD, value: bif_d, last: 1'b0};
      res_n      = res_n + 2'd1;
    end

    // The head entry may be one written by this same transaction.
    pend = (cnt_d != '0) && !await_d;
    hv   = queue_mem[head_d];
    for (int p = 0; p < NPUSH; p++) begin
      if (push_en[p] && (push_idx[p] == head_d)) begin
        hv = push_val[p];
      end
    end
    if (pend) begin
      head_d     = next_ptr(head_d);
      cnt_d      = cnt_d - CNT_W'(1);
      bif_d      = hv;
      await_d    = 1'b1;
      res[res_n] = '{kind: sc2a_pkg::KIND_CMD, value: hv, last: 1'b0};
      res_n      = res_n + 2'd1;
    end

    if (res_n != 2'd0) begin
      res[res_n - 2'd1].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q     <= 3'd0;
      in_valid_q <= 1'b0;
      shift_q    <= 2'b00;
      led_q      <= 3'd0;
      start_q    <= 1'b1;
      head_q     <= '0;
      cnt_q      <= '0;
      bif_q      <= sc2a_pkg::NO_BYTE;
      await_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        init_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (adv) begin
        shift_q <= shift_d;
        led_q   <= led_d;
        start_q <= 1'b0;
        head_q  <= head_d;
        cnt_q   <= cnt_d;
        bif_q   <= bif_d;
        await_q <= await_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      code_q <= s_axis_tdata;
    end
    if (adv) begin
      for (int p = 0; p < NPUSH; p++) begin
        if (push_en[p]) begin
          queue_mem[push_idx[p]] <= push_val[p];
        end
      end
    end
  end

  sc2a_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (adv),
    .load_n_i      (res_n),
    .load_res_i    (res),
    .free_o        (buf_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== sim/scancode_to_ascii_with_led_commands_test.sv =====
// Self-checking testbench for the set 1 scan-code decoder and its keyboard LED command queue.
module scancode_to_ascii_with_led_commands_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam logic [7:0] LETTER_FIRST = 8'h41;
  localparam logic [7:0] LETTER_LAST  = 8'h5A;
  localparam logic [2:0] LED_SCROLL   = 3'b001;
  localparam logic [2:0] LED_CAPS     = 3'b100;

  localparam logic [7:0] UNSHIFTED_KEYS [128] = '{
    'h00, 'h00, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36,
    'h37, 'h38, 'h39, 'h30, 'h2d, 'h5e, 'h08, 'h00,
    'h51, 'h57, 'h45, 'h52, 'h54, 'h59, 'h55, 'h49,
    'h4f, 'h50, 'h40, 'h5b, 'h0a, 'h00, 'h41, 'h53,
    'h44, 'h46, 'h47, 'h48, 'h4a, 'h4b, 'h4c, 'h3b,
    'h3a, 'h00, 'h00, 'h5d, 'h5a, 'h58, 'h43, 'h56,
    'h42, 'h4e, 'h4d, 'h2c, 'h2e, 'h2f, 'h00, 'h2a,
    'h00, 'h20, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h37,
    'h38, 'h39, 'h2d, 'h34, 'h35, 'h36, 'h2b, 'h31,
    'h32, 'h33, 'h30, 'h2e, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h5c, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h5c, 'h00, 'h00
  };

  localparam logic [7:0] SHIFTED_KEYS [128] = '{
    'h00, 'h00, 'h21, 'h22, 'h23, 'h24, 'h25, 'h26,
    'h27, 'h28, 'h29, 'h7e, 'h3d, 'h7e, 'h08, 'h00,
    'h51, 'h57, 'h45, 'h52, 'h54, 'h59, 'h55, 'h49,
    'h4f, 'h50, 'h60, 'h7b, 'h0a, 'h00, 'h41, 'h53,
    'h44, 'h46, 'h47, 'h48, 'h4a, 'h4b, 'h4c, 'h2b,
    'h2a, 'h00, 'h00, 'h7d, 'h5a, 'h58, 'h43, 'h56,
    'h42, 'h4e, 'h4d, 'h3c, 'h3e, 'h3f, 'h00, 'h2a,
    'h00, 'h20, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h37,
    'h38, 'h39, 'h2d, 'h34, 'h35, 'h36, 'h2b, 'h31,
    'h32, 'h33, 'h30, 'h2e, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h5f, 'h00, 'h00, 'h00, 'h00,
    'h00, 'h00, 'h00, 'h00, 'h00, 'h7c, 'h00, 'h00
  };

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } key_result_t;

  typedef struct packed {
    logic [7:0] code;
    logic       typed;
    logic       has_res;
    logic       kind;
    logic [7:0] value;
  } code_row_t;

  localparam code_row_t DIRECTED [25] = '{
    '{8'h00,                   1'b1, 1'b1, sc2a_pkg::KIND_CMD,  sc2a_pkg::CMD_LED},
    '{sc2a_pkg::SC_RESEND,     1'b1, 1'b1, sc2a_pkg::KIND_CMD,  sc2a_pkg::CMD_LED},
    '{sc2a_pkg::SC_ACK,        1'b0, 1'b0, sc2a_pkg::KIND_CHAR, 8'h00},
    '{sc2a_pkg::SC_ACK,        1'b1, 1'b0, sc2a_pkg::KIND_CHAR, 8'h00},
    '{sc2a_pkg::SC_RESEND,     1'b1, 1'b1, sc2a_pkg::KIND_CMD,  sc2a_pkg::NO_BYTE},
    '{8'h1E,                   1'b0, 1'b0, sc2a_pkg::KIND_CHAR, 8'h00},
    '{sc2a_pkg::SC_CAPS,       1'b1, 1'b1, sc2a_pkg::KIND_CMD,  sc2a_pkg::CMD_LED},
    '{sc2a_pkg::SC_ACK,        1'b0, 1'b0, sc2a_pkg::KIND_CHAR, 8'h00},
    '{8'h1E,                   1'b0, 1'b0, sc2a_pkg::KIND_CHAR, 8'h00},
    '{sc2a_pkg::SC_LSHIFT_ON,  1'b1, 1'b0, sc2a_pkg::KIND_CHAR, 8'h00},
    '{8'h02,                   1'b1, 1'b1, sc2a_pkg::KIND_CHAR, 8'h21},
    '{8'h1E,                   1'b0, 1'b0, sc2a_pkg::KIND_CHAR, 8'h00},
    '{sc2a_pkg::SC_RSHIFT_ON,  1'b1, 1'b0, sc2a_pkg::KIND_CHAR, 8'h00},
    '{sc2a_pkg::SC_LSHIFT_OFF, 1'b1, 1'b0, sc2a_pkg::KIND_CHAR, 8'h00},
    '{8'h0B,                   1'b1, 1'b1, sc2a_pkg::KIND_CHAR, 8'h7E},
    '{sc2a_pkg::SC_RSHIFT_OFF, 1'b1, 1'b0, sc2a_pkg::KIND_CHAR, 8'h00},
    '{8'h0B,                   1'b1, 1'b1, sc2a_pkg::KIND_CHAR, 8'h30},
    '{8'h7F,                   1'b1, 1'b0, sc2a_pkg::KIND_CHAR, 8'h00},
    '{8'h7D,                   1'b1, 1'b1, sc2a_pkg::KIND_CHAR, 8'h5C},
    '{sc2a_pkg::SC_SCROLL,     1'b0, 1'b0, sc2a_pkg::KIND_CHAR, 8'h00},
    '{8'hFF,                   1'b1, 1'b0, sc2a_pkg::KIND_CHAR, 8'h00},
    '{sc2a_pkg::SC_ACK,        1'b1, 1'b1, sc2a_pkg::KIND_CMD,  sc2a_pkg::CMD_LED},
    '{sc2a_pkg::SC_RESEND,     1'b1, 1'b1, sc2a_pkg::KIND_CMD,  sc2a_pkg::CMD_LED},
    '{sc2a_pkg::SC_ACK,        1'b0, 1'b0, sc2a_pkg::KIND_CHAR, 8'h00},
    '{sc2a_pkg::SC_ACK,        1'b1, 1'b0, sc2a_pkg::KIND_CHAR, 8'h00}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_wdata_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;

  scancode_to_ascii_with_led_commands u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  logic [2:0]  boot_leds;
  logic [1:0]  kb_shift;
  logic [2:0]  kb_leds;
  logic        kb_boot_pending;
  logic [7:0]  kb_fifo [sc2a_pkg::QUEUE_DEPTH];
  int unsigned kb_head;
  int unsigned kb_count;
  logic [7:0]  kb_in_flight;
  logic        kb_awaiting;

  key_result_t code_outputs [$];
  key_result_t outputs_due [$];
  code_row_t   codes_planned [$];

  bit          idle_on = 1'b1;
  int unsigned mismatches;
  int unsigned codes_taken;
  int unsigned chars_seen;
  int unsigned cmds_seen;
  int unsigned fifo_drops;
  int unsigned quiet_cycles;

  function automatic void add_output(input logic kind, input logic [7:0] value);
    code_outputs.push_back('{kind, value, 1'b0});
  endfunction

  function automatic void push_command(input logic [7:0] b);
    if (kb_count >= sc2a_pkg::QUEUE_DEPTH) begin
      fifo_drops++;
    end else begin
      kb_fifo[(kb_head + kb_count) % sc2a_pkg::QUEUE_DEPTH] = b;
      kb_count++;
    end
  endfunction

  function automatic void send_command();
    if (kb_count != 0 && !kb_awaiting) begin
      kb_in_flight = kb_fifo[kb_head];
      kb_head      = (kb_head + 1) % sc2a_pkg::QUEUE_DEPTH;
      kb_count--;
      kb_awaiting  = 1'b1;
      add_output(sc2a_pkg::KIND_CMD, kb_in_flight);
    end
  endfunction

  function automatic void decode_scan_code(input logic [7:0] code);
    logic [7:0]  ch;
    key_result_t tail;
    code_outputs.delete();
    if (kb_boot_pending) begin
      kb_boot_pending = 1'b0;
      kb_leds = boot_leds;
      push_command(sc2a_pkg::CMD_LED);
      push_command({5'b0, kb_leds});
      send_command();
    end
    ch = 8'h00;
    if (code < 8'h80) begin
      ch = (kb_shift == 2'b00) ? UNSHIFTED_KEYS[code[6:0]] : SHIFTED_KEYS[code[6:0]];
    end
    if (ch >= LETTER_FIRST && ch <= LETTER_LAST) begin
      if (((kb_leds & LED_CAPS) != 0) == (kb_shift != 2'b00)) begin
        ch = ch + sc2a_pkg::CASE_OFFSET;
      end
    end
    if (ch != 8'h00) begin
      add_output(sc2a_pkg::KIND_CHAR, ch);
    end
    case (code)
      sc2a_pkg::SC_LSHIFT_ON:  kb_shift[0] = 1'b1;
      sc2a_pkg::SC_RSHIFT_ON:  kb_shift[1] = 1'b1;
      sc2a_pkg::SC_LSHIFT_OFF: kb_shift[0] = 1'b0;
      sc2a_pkg::SC_RSHIFT_OFF: kb_shift[1] = 1'b0;
      sc2a_pkg::SC_CAPS, sc2a_pkg::SC_SCROLL: begin
        kb_leds = kb_leds ^ ((code == sc2a_pkg::SC_CAPS) ? LED_CAPS : LED_SCROLL);
        push_command(sc2a_pkg::CMD_LED);
        push_command({5'b0, kb_leds});
      end
      sc2a_pkg::SC_ACK: begin
        kb_awaiting  = 1'b0;
        kb_in_flight = sc2a_pkg::NO_BYTE;
      end
      sc2a_pkg::SC_RESEND: add_output(sc2a_pkg::KIND_CMD, kb_in_flight);
      default: ;
    endcase
    send_command();
    if (code_outputs.size() != 0) begin
      tail = code_outputs.pop_back();
      tail.last = 1'b1;
      code_outputs.push_back(tail);
    end
  endfunction

  function automatic void report_result(input string what, input key_result_t want,
                                        input key_result_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%0t: %s: expected kind %0b value %02h last %0b, got kind %0b value %02h last %0b",
               $realtime, what, want.kind, want.value, want.last, got.kind, got.value, got.last);
    end
  endfunction

  function automatic code_row_t checked_row(input logic [7:0] code);
    return '{code, 1'b0, 1'b0, sc2a_pkg::KIND_CHAR, 8'h00};
  endfunction

  function automatic logic [7:0] pick_code();
    int unsigned r;
    logic [7:0]  code;
    r = $urandom_range(99);
    if (kb_awaiting && r < 20) begin
      code = sc2a_pkg::SC_ACK;
    end else if (r < 45) begin
      code = 8'($urandom_range(8'h7F));
    end else if (r < 55) begin
      code = 8'($urandom_range(8'hFF, 8'h80));
    end else if (r < 65) begin
      case ($urandom_range(3))
        0:       code = sc2a_pkg::SC_LSHIFT_ON;
        1:       code = sc2a_pkg::SC_RSHIFT_ON;
        2:       code = sc2a_pkg::SC_LSHIFT_OFF;
        default: code = sc2a_pkg::SC_RSHIFT_OFF;
      endcase
    end else if (r < 73) begin
      code = $urandom_range(1) ? sc2a_pkg::SC_CAPS : sc2a_pkg::SC_SCROLL;
    end else if (r < 77) begin
      code = sc2a_pkg::SC_RESEND;
    end else if (r < 85) begin
      code = sc2a_pkg::SC_ACK;
    end else begin
      code = 8'($urandom);
    end
    return code;
  endfunction

  always @(negedge clk_i) begin
    m_axis_tready <= !(idle_on && $urandom_range(99) < 7);
  end

  always @(posedge clk_i) begin
    key_result_t got;
    key_result_t want;
    code_row_t   row;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tuser, m_axis_tdata, m_axis_tlast};
        if (got.kind == sc2a_pkg::KIND_CMD) cmds_seen++;
        else chars_seen++;
        if (outputs_due.size() == 0) begin
          report_result("result with nothing expected", '0, got);
        end else begin
          want = outputs_due.pop_front();
          if (got.kind !== want.kind || got.value !== want.value || got.last !== want.last) begin
            report_result("result mismatch", want, got);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        codes_taken++;
        row = codes_planned.pop_front();
        decode_scan_code(s_axis_tdata);
        if (row.typed) begin
          if (row.has_res) outputs_due.push_back('{row.kind, row.value, 1'b1});
        end else begin
          foreach (code_outputs[k]) outputs_due.push_back(code_outputs[k]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("scancode_to_ascii_with_led_commands_test: FAIL");
      $finish;
    end
  end

  task automatic write_leds(input logic [2:0] leds);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= leds;
    boot_leds    = leds;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_row(input code_row_t row);
    codes_planned.push_back(row);
    if (idle_on && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      do @(negedge clk_i); while (idle_on && $urandom_range(99) < 7);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row.code;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_codes(input int unsigned count);
    repeat (count) send_row(checked_row(pick_code()));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (codes_planned.size() != 0 || outputs_due.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 3'd0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = 8'h00;
    boot_leds       = 3'd0;
    kb_shift        = 2'b00;
    kb_leds         = 3'd0;
    kb_boot_pending = 1'b1;
    kb_head         = 0;
    kb_count        = 0;
    kb_in_flight    = sc2a_pkg::NO_BYTE;
    kb_awaiting     = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_leds(3'd0);
    write_leds(3'd7);
    write_leds(3'($urandom_range(7)));
    foreach (DIRECTED[i]) send_row(DIRECTED[i]);
    drain();

    write_leds(3'd7);
    random_codes(120);
    drain();

    write_leds(3'd0);
    idle_on = 1'b0;
    random_codes(100);
    idle_on = 1'b1;

    // Toggle the LEDs without acknowledging so the command queue overflows, then drain it.
    repeat (20) begin
      send_row(checked_row($urandom_range(1) ? sc2a_pkg::SC_CAPS : sc2a_pkg::SC_SCROLL));
    end
    while (kb_count != 0 || kb_awaiting) send_row(checked_row(sc2a_pkg::SC_ACK));
    drain();

    write_leds(3'($urandom_range(7)));
    random_codes(110);
    drain();

    $display("Sent %0d scan codes; checked %0d characters and %0d keyboard command bytes.",
             codes_taken, chars_seen, cmds_seen);
    $display("Command bytes dropped on a full queue: %0d; mismatches: %0d.",
             fifo_drops, mismatches);
    if (mismatches == 0 && outputs_due.size() == 0) begin
      $display("scancode_to_ascii_with_led_commands_test: PASS");
    end else begin
      $display("scancode_to_ascii_with_led_commands_test: FAIL");
    end
    $finish;
  end

endmodule
